// File: sv/bb5_pkg.sv
`default_nettype none

package bb5_pkg;

    // Window geometry
    localparam int KERNEL_SIZE = 5;
    localparam int HALF_LO     = KERNEL_SIZE / 2;
    localparam int HALF_HI     = KERNEL_SIZE - 1 - HALF_LO;
    localparam int TAP_COUNT   = KERNEL_SIZE * KERNEL_SIZE;

    // Data widths
    localparam int PIX_BITS    = 8;
    localparam int LINE_BITS   = (KERNEL_SIZE - 1) * PIX_BITS;
    localparam int COLSUM_BITS = PIX_BITS + $clog2(KERNEL_SIZE);

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    // Output queue
    localparam int OUTQ_DEPTH    = 8;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = OUTQ_PTR_BITS + 1;

    // One accepted item with its border masks
    typedef struct packed {
        logic                      live;
        logic                      produce;
        logic                      last;
        logic [PIX_BITS-1:0]       pixel;
        logic [KERNEL_SIZE-1:0]    row_ok;
        logic [KERNEL_SIZE-1:0]    col_ok;
    } tap_item_t;

    // One vertical column sum with its horizontal mask
    typedef struct packed {
        logic                      live;
        logic                      produce;
        logic                      last;
        logic [COLSUM_BITS-1:0]    colsum;
        logic [KERNEL_SIZE-1:0]    col_ok;
    } col_item_t;

    typedef struct packed {
        logic [PIX_BITS-1:0]       blurred;
        logic                      last;
    } res_t;

    typedef struct packed {
        logic                      push;
        res_t                      res;
    } res_push_t;

endpackage

`default_nettype wire

// File: sv/bb5_pix_if.sv
`default_nettype none

interface bb5_pix_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [bb5_pkg::PIX_BITS-1:0]  pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink (input valid, input mode, input pixel, output ready);
endinterface

`default_nettype wire

// File: sv/bb5_res_if.sv
`default_nettype none

interface bb5_res_if;
    logic                          valid;
    logic                          ready;
    logic [bb5_pkg::PIX_BITS-1:0]  blurred;
    logic                          last_of_frame;

    modport source (output valid, output blurred, output last_of_frame, input ready);
    modport sink (input valid, input blurred, input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: sv/bb5_cfg_if.sv
`default_nettype none

interface bb5_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bb5_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [bb5_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/bb5_ram.sv
`default_nettype none

module bb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port and registered read port (old data on a same-address collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/bb5_ctrl.sv
`default_nettype none

module bb5_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bb5_pix_if.sink                            pix,
    bb5_cfg_if.sink                            cfg,
    input  wire logic                          room,
    output bb5_pkg::tap_item_t                 item,
    output logic [$clog2(MAX_WIDTH)-1:0]       addr
);

    localparam int KERNEL_SIZE = bb5_pkg::KERNEL_SIZE;
    localparam int HALF_LO     = bb5_pkg::HALF_LO;
    localparam int HALF_HI     = bb5_pkg::HALF_HI;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 12;
    localparam int ROW_BITS    = 13;
    localparam int DIM_BITS    = 14;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    logic [WIDTH_BITS-1:0]  fw_reg, fw_next;
    logic [HEIGHT_BITS-1:0] fh_reg, fh_next;
    logic [COL_BITS-1:0]    in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]    in_row_reg, in_row_next;
    logic [COL_BITS-1:0]    out_col_reg, out_col_next;
    logic [DIM_BITS-1:0]    lead_reg, lead_next;
    logic [DIM_BITS-1:0]    flush_reg, flush_next;

    logic [DIM_BITS-1:0]    eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;
    logic [DIM_BITS-1:0]    lat;
    logic [DIM_BITS-1:0]    oc;
    logic                   flush_phase;
    logic                   accept;
    logic                   live;
    logic                   produce;
    logic                   last;
    logic                   col_end;
    logic                   out_col_end;
    logic                   cfg_write;
    logic                   restart;

    // Clamp the frame size and derive the lead-in length
    always_comb
    begin
        eff_w = DIM_BITS'(fw_reg);
        if (fw_reg == '0)
        begin
            eff_w = DIM_BITS'(1);
        end
        else if (eff_w > DIM_BITS'(MAX_WIDTH))
        begin
            eff_w = DIM_BITS'(MAX_WIDTH);
        end
        eff_h = (fh_reg == '0) ? HEIGHT_BITS'(1) : fh_reg;
        lat   = DIM_BITS'(HALF_HI) * eff_w + DIM_BITS'(HALF_HI);
    end

    // Handshake and frame phase
    assign pix.ready   = room;
    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && cfg.ready;
    assign accept      = pix.valid && pix.ready;
    assign flush_phase = in_row_reg >= ROW_BITS'(eff_h);
    assign live        = accept && (pix.mode == flush_phase);
    assign produce     = lead_reg == lat;
    assign last        = flush_phase && (flush_reg == lat - DIM_BITS'(1));
    assign oc          = DIM_BITS'(out_col_reg);
    assign col_end     = (DIM_BITS'(in_col_reg) + DIM_BITS'(1)) == eff_w;
    assign out_col_end = (oc + DIM_BITS'(1)) == eff_w;

    // Build the item with its row and column border masks
    always_comb
    begin
        item.live    = live;
        item.produce = produce;
        item.last    = last;
        item.pixel   = flush_phase ? '0 : pix.pixel;
        for (int d = 0; d < KERNEL_SIZE; d++)
        begin
            item.row_ok[d] = in_row_reg >= ROW_BITS'(d);
        end
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            item.col_ok[k] = (oc + DIM_BITS'(k) >= DIM_BITS'(HALF_LO)) &&
                             (oc + DIM_BITS'(k) < eff_w + DIM_BITS'(HALF_LO));
        end
    end

    assign addr = in_col_reg;

    // Update registers and frame counters
    always_comb
    begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        lead_next    = lead_reg;
        flush_next   = flush_reg;
        restart      = 1'b0;

        if (cfg_write)
        begin
            case (cfg.index)
                bb5_pkg::REG_FRAME_WIDTH:
                begin
                    fw_next = cfg.data[WIDTH_BITS-1:0];
                    restart = 1'b1;
                end
                bb5_pkg::REG_FRAME_HEIGHT:
                begin
                    fh_next = cfg.data[HEIGHT_BITS-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart || (!cfg_write && live && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            lead_next    = '0;
            flush_next   = '0;
        end
        else if (!cfg_write && live)
        begin
            if (col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_BITS'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
            if (produce)
            begin
                out_col_next = out_col_end ? '0 : out_col_reg + COL_BITS'(1);
            end
            else
            begin
                lead_next = lead_reg + DIM_BITS'(1);
            end
            if (flush_phase)
            begin
                flush_next = flush_reg + DIM_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= WIDTH_RESET;
            fh_reg      <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            lead_reg    <= '0;
            flush_reg   <= '0;
        end
        else
        begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            lead_reg    <= lead_next;
            flush_reg   <= flush_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/bb5_column.sv
`default_nettype none

module bb5_column #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bb5_pkg::tap_item_t            item,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  addr,
    output bb5_pkg::col_item_t                 col
);

    localparam int KERNEL_SIZE = bb5_pkg::KERNEL_SIZE;
    localparam int PIX_BITS    = bb5_pkg::PIX_BITS;
    localparam int LINE_BITS   = bb5_pkg::LINE_BITS;
    localparam int COLSUM_BITS = bb5_pkg::COLSUM_BITS;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);

    logic                     s1_live_reg;
    bb5_pkg::tap_item_t       s1_item_reg;
    logic [COL_BITS-1:0]      s1_addr_reg;
    logic                     fwd_hit_reg, fwd_hit_next;
    logic [LINE_BITS-1:0]     fwd_data_reg;

    logic [LINE_BITS-1:0]     rdata;
    logic [LINE_BITS-1:0]     rows;
    logic [LINE_BITS-1:0]     wdata;
    logic [COLSUM_BITS-1:0]   colsum;

    logic                     col_live_reg;
    bb5_pkg::col_item_t       col_data_reg;

    // Line store: one word per column holds the previous rows, newest in the low byte
    bb5_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (s1_live_reg),
        .waddr (s1_addr_reg),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    // Take the word written last cycle when the read hit the same column
    assign rows         = fwd_hit_reg ? fwd_data_reg : rdata;
    assign wdata        = {rows[LINE_BITS-PIX_BITS-1:0], s1_item_reg.pixel};
    assign fwd_hit_next = s1_live_reg && item.live && (addr == s1_addr_reg);

    // Sum the column, dropping rows above the frame
    always_comb
    begin
        colsum = s1_item_reg.row_ok[0] ? COLSUM_BITS'(s1_item_reg.pixel) : '0;
        for (int d = 1; d < KERNEL_SIZE; d++)
        begin
            if (s1_item_reg.row_ok[d])
            begin
                colsum = colsum + COLSUM_BITS'(rows[(d - 1) * PIX_BITS +: PIX_BITS]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_live_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            col_live_reg <= 1'b0;
        end
        else
        begin
            s1_live_reg  <= item.live;
            fwd_hit_reg  <= fwd_hit_next;
            col_live_reg <= s1_live_reg;
        end
    end

    // Hold the payload of both stages
    always_ff @(posedge clk)
    begin
        s1_item_reg          <= item;
        s1_addr_reg          <= addr;
        fwd_data_reg         <= wdata;
        col_data_reg.live    <= s1_item_reg.live;
        col_data_reg.produce <= s1_item_reg.produce;
        col_data_reg.last    <= s1_item_reg.last;
        col_data_reg.colsum  <= colsum;
        col_data_reg.col_ok  <= s1_item_reg.col_ok;
    end

    always_comb
    begin
        col      = col_data_reg;
        col.live = col_live_reg;
    end

endmodule

`default_nettype wire

// File: sv/bb5_window.sv
`default_nettype none

module bb5_window (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bb5_pkg::col_item_t   col,
    output bb5_pkg::res_push_t        push
);

    localparam int KERNEL_SIZE = bb5_pkg::KERNEL_SIZE;
    localparam int TAP_COUNT   = bb5_pkg::TAP_COUNT;
    localparam int PIX_BITS    = bb5_pkg::PIX_BITS;
    localparam int COLSUM_BITS = bb5_pkg::COLSUM_BITS;
    localparam int SUM_BITS    = PIX_BITS + $clog2(TAP_COUNT);
    // Reciprocal of the tap count, exact for every window sum
    localparam int RECIP_SHIFT = SUM_BITS + 6;
    localparam int MULT_BITS   = RECIP_SHIFT - 3;
    localparam int PROD_BITS   = SUM_BITS + MULT_BITS;
    localparam logic [MULT_BITS-1:0] RECIP_MULT =
        MULT_BITS'((2 ** RECIP_SHIFT + TAP_COUNT - 1) / TAP_COUNT);

    logic [COLSUM_BITS-1:0] hist_reg [0:KERNEL_SIZE-2];
    logic                   s3_live_reg;
    logic                   s3_last_reg;
    logic [SUM_BITS-1:0]    s3_sum_reg;

    logic [SUM_BITS-1:0]    win_sum;
    logic [PROD_BITS-1:0]   prod;

    // Add the masked columns; the newest column is the rightmost tap
    always_comb
    begin
        win_sum = col.col_ok[KERNEL_SIZE-1] ? SUM_BITS'(col.colsum) : '0;
        for (int k = 0; k < KERNEL_SIZE - 1; k++)
        begin
            if (col.col_ok[k])
            begin
                win_sum = win_sum + SUM_BITS'(hist_reg[KERNEL_SIZE-2-k]);
            end
        end
    end

    // Shift the column history on every live item
    always_ff @(posedge clk)
    begin
        if (col.live)
        begin
            hist_reg[0] <= col.colsum;
            for (int j = 1; j < KERNEL_SIZE - 1; j++)
            begin
                hist_reg[j] <= hist_reg[j-1];
            end
        end
        s3_sum_reg  <= win_sum;
        s3_last_reg <= col.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_live_reg <= 1'b0;
        end
        else
        begin
            s3_live_reg <= col.live && col.produce;
        end
    end

    // Divide by multiplying with the reciprocal
    assign prod             = PROD_BITS'(s3_sum_reg) * PROD_BITS'(RECIP_MULT);
    assign push.push        = s3_live_reg;
    assign push.res.blurred = prod[RECIP_SHIFT +: PIX_BITS];
    assign push.res.last    = s3_last_reg;

endmodule

`default_nettype wire

// File: sv/bb5_fifo.sv
`default_nettype none

module bb5_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bb5_pkg::res_push_t   push,
    input  wire logic                 claim,
    output logic                      room,
    bb5_res_if.source                 res
);

    localparam int OUTQ_DEPTH    = bb5_pkg::OUTQ_DEPTH;
    localparam int OUTQ_PTR_BITS = bb5_pkg::OUTQ_PTR_BITS;
    localparam int OUTQ_CNT_BITS = bb5_pkg::OUTQ_CNT_BITS;

    bb5_pkg::res_t              q_reg [0:OUTQ_DEPTH-1];
    logic [OUTQ_PTR_BITS-1:0]   wr_ptr_reg;
    logic [OUTQ_PTR_BITS-1:0]   rd_ptr_reg;
    logic [OUTQ_CNT_BITS-1:0]   count_reg, count_next;
    logic [OUTQ_CNT_BITS-1:0]   credits_reg, credits_next;
    logic                       pop;

    // Present the head entry
    assign res.valid         = count_reg != '0;
    assign res.blurred       = q_reg[rd_ptr_reg].blurred;
    assign res.last_of_frame = q_reg[rd_ptr_reg].last;
    assign pop               = res.valid && res.ready;

    // Reserve a slot for every result in flight so the pipeline never stalls
    assign room         = credits_reg < OUTQ_CNT_BITS'(OUTQ_DEPTH);
    assign credits_next = credits_reg + OUTQ_CNT_BITS'(claim) - OUTQ_CNT_BITS'(pop);
    assign count_next   = count_reg + OUTQ_CNT_BITS'(push.push) - OUTQ_CNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            q_reg[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            credits_reg <= '0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_BITS'(1);
            end
            count_reg   <= count_next;
            credits_reg <= credits_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/box_blur_5x5.sv
// 5x5 mean blur of a raster pixel stream, one item accepted per clock while the queue has room.
// The result for the item that completes a window goes through the line store read, the
// column sum, the window sum and the reciprocal multiply, then into the output queue.
// Throughput: one item per cycle; input is held off only while eight results are queued
// or still in the pipeline, so an 8-entry output queue absorbs short output stalls.
// Reset (rst_n low, asynchronous): frame counters clear, frame_width = 640,
// frame_height = 480; the line store is not cleared, border masks hide its old contents.
`default_nettype none

module box_blur_5x5 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bb5_pix_if.sink     pix,
    bb5_res_if.source   res,
    bb5_cfg_if.sink     cfg
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    bb5_pkg::tap_item_t  item;
    logic [COL_BITS-1:0] addr;
    bb5_pkg::col_item_t  col;
    bb5_pkg::res_push_t  push;
    logic                room;
    logic                claim;

    // Count frame position and build border masks
    bb5_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .room  (room),
        .item  (item),
        .addr  (addr)
    );

    // Line store and vertical sums
    bb5_column #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_column (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .addr  (addr),
        .col   (col)
    );

    // Horizontal sum and division
    bb5_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .col   (col),
        .push  (push)
    );

    // Queue results toward the consumer
    assign claim = item.live && item.produce;

    bb5_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .claim (claim),
        .room  (room),
        .res   (res)
    );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;

    localparam int KERNEL_SIZE      = bb5_pkg::KERNEL_SIZE;
    localparam int HALF_LO          = bb5_pkg::HALF_LO;
    localparam int HALF_HI          = bb5_pkg::HALF_HI;
    localparam int TAP_COUNT        = bb5_pkg::TAP_COUNT;
    localparam int CFG_INDEX_BITS   = bb5_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS    = bb5_pkg::CFG_DATA_BITS;
    localparam int MAX_W            = 1024;
    localparam int RING_DEPTH       = (KERNEL_SIZE - 1) * MAX_W + KERNEL_SIZE;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int RANDOM_ITEMS     = 330;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = bb5_pkg::REG_FRAME_WIDTH;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = bb5_pkg::REG_FRAME_HEIGHT;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED     = CFG_INDEX_BITS'(3);

    typedef enum {PIX_RANDOM, PIX_BRIGHT, PIX_DARK} pix_style_t;

    typedef struct {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } reg_write_t;

    // Track frame position and line store, predict each blurred pixel
    class mean_blur_sb_t;
        logic [10:0]     width_reg;
        logic [11:0]     height_reg;
        logic [7:0]      ring [RING_DEPTH];
        int              item_pos;
        int              row_pos;
        int              col_pos;
        bb5_pkg::res_t   blurred_q[$];
        int              errors;
        int              results_checked;
        int              dropped_items;
        int              frames_done;
        int              widest;

        function new();
            width_reg  = 11'd640;
            height_reg = 12'd480;
            foreach (ring[i])
                ring[i] = 8'd0;
            restart();
            errors          = 0;
            results_checked = 0;
            dropped_items   = 0;
            frames_done     = 0;
            widest          = 0;
        endfunction

        function void restart();
            item_pos = 0;
            row_pos  = 0;
            col_pos  = 0;
        endfunction

        function int eff_width();
            int w;
            w = int'(width_reg);
            if (w == 0)
                w = 1;
            if (w > MAX_W)
                w = MAX_W;
            return w;
        endfunction

        function int eff_height();
            return (height_reg == 12'd0) ? 1 : int'(height_reg);
        endfunction

        function int frame_items();
            return eff_height() * eff_width() + HALF_HI * eff_width() + HALF_HI;
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_FRAME_WIDTH)
            begin
                width_reg = data[10:0];
                restart();
            end
            else if (idx == REG_FRAME_HEIGHT)
            begin
                height_reg = data;
                restart();
            end
        endfunction

        // Note one accepted input transfer and queue the pixel it completes
        function void take_item(logic mode, logic [7:0] pix);
            int            w;
            int            h;
            int            npix;
            int            lat;
            int            total;
            int            sum;
            int            rr;
            int            cc;
            int            dy;
            int            dx;
            logic          want;
            bb5_pkg::res_t r;
            w     = eff_width();
            h     = eff_height();
            npix  = w * h;
            lat   = HALF_HI * w + HALF_HI;
            total = npix + lat;
            if (item_pos >= total)
                restart();
            want = (item_pos < npix) ? MODE_PIXEL : MODE_FLUSH;
            if (mode != want)
            begin
                dropped_items++;
                return;
            end
            if (w > widest)
                widest = w;
            if (want == MODE_PIXEL)
                ring[item_pos % RING_DEPTH] = pix;
            if (item_pos >= lat)
            begin
                sum = 0;
                for (dy = -HALF_LO; dy <= HALF_HI; dy++)
                begin
                    rr = row_pos + dy;
                    if (rr < 0 || rr >= h)
                        continue;
                    for (dx = -HALF_LO; dx <= HALF_HI; dx++)
                    begin
                        cc = col_pos + dx;
                        if (cc < 0 || cc >= w)
                            continue;
                        sum += int'(ring[(rr * w + cc) % RING_DEPTH]);
                    end
                end
                r.blurred = 8'(sum / TAP_COUNT);
                r.last    = (item_pos + 1 == total);
                blurred_q.push_back(r);
                col_pos++;
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    row_pos++;
                end
            end
            item_pos++;
            if (item_pos >= total)
            begin
                restart();
                frames_done++;
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [7:0] blurred, logic last_of_frame);
            bb5_pkg::res_t e;
            if (blurred_q.size() == 0)
            begin
                $error("unexpected result: blurred %0d last_of_frame %0d",
                       blurred, last_of_frame);
                errors++;
                return;
            end
            e = blurred_q.pop_front();
            results_checked++;
            if (blurred !== e.blurred)
            begin
                $error("blurred: expected %0d, got %0d", e.blurred, blurred);
                errors++;
            end
            if (last_of_frame !== e.last)
            begin
                $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bb5_pix_if pix_bus();
    bb5_res_if res_bus();
    bb5_cfg_if cfg_bus();

    box_blur_5x5 #(.MAX_WIDTH(MAX_W)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    mean_blur_sb_t blur_sb;
    reg_write_t    reg_writes[$];
    int            burst_left = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    bit            long_hold_req = 0;
    int            long_holds_done = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("box_blur_5x5: mismatch");
            $finish;
        end
    end

    // Observe input and result transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_bus.valid && pix_bus.ready)
                blur_sb.take_item(pix_bus.mode, pix_bus.pixel);
            if (res_bus.valid && res_bus.ready)
                blur_sb.check_result(res_bus.blurred, res_bus.last_of_frame);
        end
    end

    // Result side: segments of steady, random, sparse and periodic ready, plus one long hold-off
    initial
    begin
        int seg_kind;
        int seg_len;
        int phase;
        res_bus.ready = 1'b0;
        phase = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            seg_kind = $urandom_range(0, 7);
            seg_len  = $urandom_range(10, 120);
            repeat (seg_len)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 0;
                    res_bus.ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                    long_holds_done++;
                end
                case (seg_kind)
                    0, 1, 2: res_bus.ready <= 1'b1;
                    3, 4:    res_bus.ready <= 1'($urandom_range(0, 1));
                    5:       res_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: res_bus.ready <= (phase % 3 != 0);
                endcase
                phase++;
                @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 15);
    endfunction

    function automatic int pick_burst();
        return ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    endfunction

    function automatic logic [7:0] pick_pixel(pix_style_t style);
        int r;
        if (style == PIX_BRIGHT)
            return 8'hFF;
        if (style == PIX_DARK)
            return 8'h00;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one item, idling between bursts, and hold it until the transfer
    task automatic send_item(input logic item_mode, input logic [7:0] item_pixel);
        int gap;
        if (burst_left == 0)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                pix_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = pick_burst();
        end
        pix_bus.valid <= 1'b1;
        pix_bus.mode  <= item_mode;
        pix_bus.pixel <= item_pixel;
        do @(posedge clk); while (!pix_bus.ready);
        burst_left--;
    endtask

    // Send frame positions from_pos up to to_pos, with out-of-phase items mixed in
    task automatic run_frame(input int w, input int h, input int from_pos, input int to_pos,
                             input pix_style_t style, input int noise_pct);
        int npix;
        int pos;
        npix = w * h;
        for (pos = from_pos; pos < to_pos; pos++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item((pos < npix) ? MODE_FLUSH : MODE_PIXEL, 8'($urandom_range(0, 255)));
            if (pos < npix)
                send_item(MODE_PIXEL, pick_pixel(style));
            else
                send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
            items_sent++;
        end
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        burst_left = 0;
        while (blur_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_write(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
        reg_write_t wr;
        wr.index = idx;
        wr.data  = data;
        reg_writes.push_back(wr);
    endtask

    // Issue queued register writes back to back
    task automatic issue_writes();
        reg_write_t wr;
        while (reg_writes.size() > 0)
        begin
            wr = reg_writes.pop_front();
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= wr.index;
            cfg_bus.data  <= wr.data;
            do @(posedge clk); while (!cfg_bus.ready);
            blur_sb.write_reg(wr.index, wr.data);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_frame_size(input logic [CFG_DATA_BITS-1:0] wdata,
                                  input logic [CFG_DATA_BITS-1:0] hdata);
        wait_idle();
        queue_write(REG_FRAME_WIDTH, wdata);
        queue_write(REG_FRAME_HEIGHT, hdata);
        issue_writes();
    endtask

    // Random frames: mostly small, a few wide ones, some cut short
    task automatic run_random_frames();
        int         start_items;
        int         r;
        int         w;
        int         h;
        int         total;
        int         stop;
        bit         was_cut;
        bit         wide;
        pix_style_t style;
        logic [CFG_DATA_BITS-1:0] wdata;
        logic [CFG_DATA_BITS-1:0] hdata;
        start_items = items_sent;
        was_cut = 1;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if (was_cut || $urandom_range(0, 9) < 7)
            begin
                wait_idle();
                r = $urandom_range(0, 99);
                if (r < 75)
                    wdata = CFG_DATA_BITS'($urandom_range(1, 12));
                else if (r < 90)
                    wdata = CFG_DATA_BITS'($urandom_range(13, 48));
                else if (r < 95)
                    wdata = '0;
                else
                    wdata = CFG_DATA_BITS'(2048 + $urandom_range(1, 12));
                r = $urandom_range(0, 9);
                if (r != 0)
                    queue_write(REG_FRAME_WIDTH, wdata);
                wide = (r != 0) ? (wdata[10:0] > 11'd12) : (blur_sb.eff_width() > 12);
                if (wide)
                    hdata = CFG_DATA_BITS'($urandom_range(1, 3));
                else if ($urandom_range(0, 19) == 0)
                    hdata = '0;
                else
                    hdata = CFG_DATA_BITS'($urandom_range(1, 10));
                if (r != 1)
                    queue_write(REG_FRAME_HEIGHT, hdata);
                issue_writes();
            end
            w = blur_sb.eff_width();
            h = blur_sb.eff_height();
            total = blur_sb.frame_items();
            was_cut = ($urandom_range(0, 9) == 0);
            stop = was_cut ? $urandom_range(1, total - 1) : total;
            r = $urandom_range(0, 19);
            style = (r == 0) ? PIX_BRIGHT : (r == 1) ? PIX_DARK : PIX_RANDOM;
            run_frame(w, h, 0, stop, style, ($urandom_range(0, 3) == 0) ? 0 : 8);
        end
    endtask

    // Main sequence
    initial
    begin
        blur_sb = new();
        rst_n         = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.mode  = MODE_PIXEL;
        pix_bus.pixel = 8'd0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_FRAME_WIDTH;
        cfg_bus.data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width of 640: enough rows to get a few pixels out
        run_frame(640, 480, 0, 1290, PIX_RANDOM, 0);

        // Zero size reads as 1x1; out-of-phase items on both sides of the frame
        set_frame_size('0, '0);
        send_item(MODE_FLUSH, 8'hAA);
        send_item(MODE_PIXEL, 8'hFF);
        send_item(MODE_PIXEL, 8'h55);
        repeat (4) send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
        run_frame(1, 1, 0, 5, PIX_DARK, 0);

        // Tiny frame at full brightness
        set_frame_size(CFG_DATA_BITS'(3), CFG_DATA_BITS'(2));
        run_frame(3, 2, 0, blur_sb.frame_items(), PIX_BRIGHT, 0);

        // Write to an unmapped index mid-frame must not restart the frame
        set_frame_size(CFG_DATA_BITS'(4), CFG_DATA_BITS'(3));
        run_frame(4, 3, 0, 7, PIX_RANDOM, 0);
        wait_idle();
        queue_write(REG_UNMAPPED, CFG_DATA_BITS'($urandom_range(0, 4095)));
        issue_writes();
        run_frame(4, 3, 7, blur_sb.frame_items(), PIX_RANDOM, 0);

        // Tallest height, cut short
        set_frame_size(CFG_DATA_BITS'(1), 12'hFFF);
        run_frame(1, 4095, 0, 40, PIX_RANDOM, 5);

        // Long receiver hold-off while a whole frame keeps coming in
        set_frame_size(CFG_DATA_BITS'(12), CFG_DATA_BITS'(10));
        long_hold_req = 1;
        run_frame(12, 10, 0, blur_sb.frame_items(), PIX_RANDOM, 0);

        run_random_frames();

        wait_idle();
        $display("Checked %0d blurred pixels over %0d complete frames;",
                 blur_sb.results_checked, blur_sb.frames_done);
        $display("%0d out-of-phase items dropped, %0d items sent, widest frame %0d, %0d long holds.",
                 blur_sb.dropped_items, items_sent, blur_sb.widest, long_holds_done);
        if (blur_sb.errors == 0 && blur_sb.pending() == 0)
            $display("box_blur_5x5: match");
        else
            $display("box_blur_5x5: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
